>>> rtl/core/rmap_pkg.sv
// shared types, constants and helper functions for the region map allocator
// no dependencies; used by rmap_mem, rmap_seq and memory_region_map_allocator
`timescale 1ns / 1ps

package rmap_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int RW = CW + 1;
  localparam int IW = (RW > 6) ? RW : 6;

  typedef logic [AW-1:0] addr_t;
  typedef logic [CW-1:0] cnt_t;

  // operation codes
  localparam logic [2:0] MODE_CLAIM = 3'd0;
  localparam logic [2:0] MODE_TAG   = 3'd1;
  localparam logic [2:0] MODE_UNTAG = 3'd2;
  localparam logic [2:0] MODE_FIND  = 3'd3;
  localparam logic [2:0] MODE_READ  = 3'd4;

  // result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_OVF     = 3'd1;
  localparam logic [2:0] ST_ALIGN   = 3'd2;
  localparam logic [2:0] ST_NONE    = 3'd3;
  localparam logic [2:0] ST_RANGE   = 3'd4;

  // tag match rules
  localparam logic [2:0] RULE_IGNORE  = 3'd0;
  localparam logic [2:0] RULE_EXACT   = 3'd1;
  localparam logic [2:0] RULE_ALL_SET = 3'd2;
  localparam logic [2:0] RULE_ANY_SET = 3'd3;
  localparam logic [2:0] RULE_ALL_CLR = 3'd4;
  localparam logic [2:0] RULE_ANY_CLR = 3'd5;

  // configuration register indexes
  localparam logic REG_USABLE = 1'b0;
  localparam logic REG_USED   = 1'b1;

  typedef struct packed {
    logic [63:0] start;
    logic [63:0] len;
    logic [7:0]  kind;
    logic [31:0] tags;
  } entry_t;

  typedef struct packed {
    logic        wr_en;
    addr_t       wr_addr;
    entry_t      wr_data;
    addr_t       rd_addr;
  } mem_req_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [63:0] start_req;
    logic [63:0] size;
    logic [7:0]  region_type;
    logic [31:0] mask;
    logic [63:0] align;
    logic [2:0]  match_rule;
    logic [5:0]  entry_index;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] address;
    logic [63:0] entry_length;
    logic [7:0]  entry_type;
    logic [31:0] entry_tags;
    logic [6:0]  entry_total;
  } res_t;

  // how an entry is cut around the request range
  typedef enum logic [2:0] {
    SPLIT_NONE, SPLIT_INS, SPLIT_GAP, SPLIT_FULL, SPLIT_HEAD, SPLIT_TAIL, SPLIT_MID
  } split_e;

  // piece boundary sources
  typedef enum logic [1:0] {BND_ES, BND_BASE, BND_END, BND_EE} bnd_e;

  typedef struct packed {
    bnd_e s;
    bnd_e t;
    logic hit;
  } piece_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_CLIP, S_END, S_LOOP, S_LD, S_EVAL, S_SH, S_SHW, S_WR, S_UPD,
    S_M_TOP, S_M_LD0, S_M_LD1, S_C_SH, S_C_SHW,
    S_F_CHK, S_F_TOP, S_F_LD, S_F_A, S_F_B, S_R_LD, S_DONE
  } state_e;

  function automatic piece_t piece_of(split_e sp, logic [1:0] j);
    piece_t p;
    p = '{s: BND_ES, t: BND_EE, hit: 1'b1};
    case (sp)
      SPLIT_INS: p = '{s: BND_BASE, t: BND_END, hit: 1'b1};
      SPLIT_GAP: p = '{s: BND_BASE, t: BND_ES, hit: 1'b1};
      SPLIT_FULL: p = '{s: BND_ES, t: BND_EE, hit: 1'b1};
      SPLIT_HEAD: begin
        if (j == 2'd0) p = '{s: BND_ES, t: BND_END, hit: 1'b1};
        else p = '{s: BND_END, t: BND_EE, hit: 1'b0};
      end
      SPLIT_TAIL: begin
        if (j == 2'd0) p = '{s: BND_ES, t: BND_BASE, hit: 1'b0};
        else p = '{s: BND_BASE, t: BND_EE, hit: 1'b1};
      end
      SPLIT_MID: begin
        if (j == 2'd0) p = '{s: BND_ES, t: BND_BASE, hit: 1'b0};
        else if (j == 2'd1) p = '{s: BND_BASE, t: BND_END, hit: 1'b1};
        else p = '{s: BND_END, t: BND_EE, hit: 1'b0};
      end
      default: p = '{s: BND_ES, t: BND_EE, hit: 1'b0};
    endcase
    return p;
  endfunction

  function automatic logic [1:0] piece_cnt(split_e sp);
    logic [1:0] n;
    case (sp)
      SPLIT_HEAD, SPLIT_TAIL: n = 2'd2;
      SPLIT_MID: n = 2'd3;
      default: n = 2'd1;
    endcase
    return n;
  endfunction

  function automatic logic [1:0] shift_amt(split_e sp);
    logic [1:0] n;
    case (sp)
      SPLIT_INS, SPLIT_GAP, SPLIT_HEAD, SPLIT_TAIL: n = 2'd1;
      SPLIT_MID: n = 2'd2;
      default: n = 2'd0;
    endcase
    return n;
  endfunction

  function automatic logic tags_match(logic [31:0] tags, logic [31:0] mask,
                                      logic [2:0] rule);
    logic m;
    case (rule)
      RULE_IGNORE:  m = 1'b1;
      RULE_EXACT:   m = (tags == mask);
      RULE_ALL_SET: m = ((tags & mask) == mask);
      RULE_ANY_SET: m = ((tags & mask) != 32'd0);
      RULE_ALL_CLR: m = ((~tags & mask) == mask);
      RULE_ANY_CLR: m = ((~tags & mask) != 32'd0);
      default:      m = 1'b0;
    endcase
    return m;
  endfunction

endpackage

>>> rtl/core/rmap_mem.sv
// region table storage: one write port, one registered read port
// depends on rmap_pkg
`timescale 1ns / 1ps

module rmap_mem (
  input  logic              clk,
  input  rmap_pkg::mem_req_t mreq,
  output rmap_pkg::entry_t   rd_data
);

  rmap_pkg::entry_t ram [rmap_pkg::MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (mreq.wr_en) begin
      ram[mreq.wr_addr] <= mreq.wr_data;
    end
    rd_data <= ram[mreq.rd_addr];
  end

endmodule

>>> rtl/core/rmap_seq.sv
// sequencer and shared datapath that walks, shifts, splits and merges the table
// depends on rmap_pkg; drives rmap_mem through a mem_req_t
`timescale 1ns / 1ps

module rmap_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  rmap_pkg::req_t     req,
  input  logic [7:0]         usable_code,
  input  logic [7:0]         used_code,
  input  logic               res_ready,
  input  rmap_pkg::entry_t   rd_data,
  output rmap_pkg::mem_req_t mreq,
  output logic               idle,
  output logic               res_valid,
  output rmap_pkg::res_t     res
);

  rmap_pkg::state_e st, st_next;
  rmap_pkg::cnt_t   held, held_next, i, i_next, k, k_next, pos, pos_next;
  rmap_pkg::split_e split, split_next;
  rmap_pkg::entry_t e, e_next;
  logic [2:0]  op, op_next, rule, rule_next;
  logic [5:0]  idx, idx_next;
  logic [63:0] base, base_next, span, span_next, endr, endr_next, ee, ee_next;
  logic [63:0] want, want_next, align, align_next, amask, amask_next;
  logic [63:0] faddr, faddr_next;
  logic [7:0]  kind, kind_next;
  logic [31:0] mask, mask_next;
  logic [1:0]  j, j_next, amt, amt_next;
  logic        fskip, fskip_next;
  logic [2:0]  r_status, r_status_next;
  logic [63:0] r_addr, r_addr_next, r_len, r_len_next;
  logic [7:0]  r_type, r_type_next;
  logic [31:0] r_tags, r_tags_next;

  logic is_tag;
  assign is_tag = (op == rmap_pkg::MODE_TAG) || (op == rmap_pkg::MODE_UNTAG);

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= rmap_pkg::S_IDLE;
      held <= '0;
    end else begin
      st   <= st_next;
      held <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    i <= i_next; k <= k_next; pos <= pos_next; split <= split_next; e <= e_next;
    op <= op_next; rule <= rule_next; idx <= idx_next; base <= base_next;
    span <= span_next; endr <= endr_next; ee <= ee_next; want <= want_next;
    align <= align_next; amask <= amask_next; faddr <= faddr_next;
    kind <= kind_next; mask <= mask_next; j <= j_next; amt <= amt_next;
    fskip <= fskip_next; r_status <= r_status_next; r_addr <= r_addr_next;
    r_len <= r_len_next; r_type <= r_type_next; r_tags <= r_tags_next;
  end

  always_comb begin
    rmap_pkg::piece_t pc;
    rmap_pkg::split_e sp;
    rmap_pkg::cnt_t   slot, sh_dst;
    logic [rmap_pkg::RW-1:0] room;
    logic [rmap_pkg::IW-1:0] idx_w;
    logic [63:0] bs, bt;
    logic [31:0] tnew;

    st_next = st; held_next = held; i_next = i; k_next = k; pos_next = pos;
    split_next = split; e_next = e; op_next = op; rule_next = rule;
    idx_next = idx; base_next = base; span_next = span; endr_next = endr;
    ee_next = ee; want_next = want; align_next = align; amask_next = amask;
    faddr_next = faddr; kind_next = kind; mask_next = mask; j_next = j;
    amt_next = amt; fskip_next = fskip; r_status_next = r_status;
    r_addr_next = r_addr; r_len_next = r_len; r_type_next = r_type;
    r_tags_next = r_tags;
    mreq = '0;
    mreq.wr_data = e;

    pc     = rmap_pkg::piece_of(split, j);
    sp     = rmap_pkg::SPLIT_NONE;
    slot   = i + rmap_pkg::cnt_t'(j);
    sh_dst = k - rmap_pkg::cnt_t'(1) + rmap_pkg::cnt_t'(amt);
    room   = '0;
    idx_w  = rmap_pkg::IW'(idx);
    tnew   = (op == rmap_pkg::MODE_TAG) ? (e.tags | mask) : (e.tags & ~mask);

    case (pc.s)
      rmap_pkg::BND_ES:   bs = e.start;
      rmap_pkg::BND_BASE: bs = base;
      rmap_pkg::BND_END:  bs = endr;
      default:            bs = ee;
    endcase
    case (pc.t)
      rmap_pkg::BND_ES:   bt = e.start;
      rmap_pkg::BND_BASE: bt = base;
      rmap_pkg::BND_END:  bt = endr;
      default:            bt = ee;
    endcase

    case (st)
      rmap_pkg::S_IDLE: begin
        if (start) begin
          op_next = req.mode; base_next = req.start_req; span_next = req.size;
          want_next = req.size; kind_next = req.region_type; mask_next = req.mask;
          align_next = req.align; rule_next = req.match_rule;
          idx_next = req.entry_index;
          r_status_next = rmap_pkg::ST_OK; r_addr_next = '0; r_len_next = '0;
          r_type_next = '0; r_tags_next = '0;
          st_next = rmap_pkg::S_DISP;
        end
      end
      rmap_pkg::S_DISP: begin
        case (op)
          rmap_pkg::MODE_CLAIM, rmap_pkg::MODE_TAG, rmap_pkg::MODE_UNTAG:
            st_next = rmap_pkg::S_CLIP;
          rmap_pkg::MODE_FIND: st_next = rmap_pkg::S_F_CHK;
          rmap_pkg::MODE_READ: begin
            if (idx_w < rmap_pkg::IW'(held)) begin
              mreq.rd_addr = idx_w[rmap_pkg::AW-1:0];
              st_next = rmap_pkg::S_R_LD;
            end else begin
              r_status_next = rmap_pkg::ST_RANGE;
              st_next = rmap_pkg::S_DONE;
            end
          end
          default: st_next = rmap_pkg::S_DONE;
        endcase
      end
      // cut the range so it ends at the top address
      rmap_pkg::S_CLIP: begin
        if (span > ~base) span_next = ~base;
        i_next = '0;
        st_next = rmap_pkg::S_END;
      end
      rmap_pkg::S_END: begin
        endr_next = base + span;
        if (is_tag && span == 64'd0) st_next = rmap_pkg::S_DONE;
        else st_next = rmap_pkg::S_LOOP;
      end
      rmap_pkg::S_LOOP: begin
        if (i < held && (is_tag || span != 64'd0)) begin
          mreq.rd_addr = i[rmap_pkg::AW-1:0];
          st_next = rmap_pkg::S_LD;
        end else if (is_tag) begin
          st_next = rmap_pkg::S_DONE;
        end else if (span != 64'd0) begin
          // remainder past the last entry is appended
          if (rmap_pkg::RW'(held) + rmap_pkg::RW'(1) > rmap_pkg::RW'(rmap_pkg::MAX_ENTRIES)) begin
            r_status_next = rmap_pkg::ST_OVF;
            st_next = rmap_pkg::S_DONE;
          end else begin
            split_next = rmap_pkg::SPLIT_INS;
            i_next = held; pos_next = held; k_next = held; amt_next = 2'd1;
            st_next = rmap_pkg::S_SH;
          end
        end else begin
          i_next = '0;
          st_next = rmap_pkg::S_M_TOP;
        end
      end
      rmap_pkg::S_LD: begin
        e_next = rd_data;
        ee_next = rd_data.start + rd_data.len;
        st_next = rmap_pkg::S_EVAL;
      end
      rmap_pkg::S_EVAL: begin
        if (!is_tag) begin
          if (endr <= e.start) sp = rmap_pkg::SPLIT_INS;
          else if (base < e.start) sp = rmap_pkg::SPLIT_GAP;
          else if (base == e.start)
            sp = (span >= e.len) ? rmap_pkg::SPLIT_FULL : rmap_pkg::SPLIT_HEAD;
          else if (base < ee)
            sp = (endr >= ee) ? rmap_pkg::SPLIT_TAIL : rmap_pkg::SPLIT_MID;
        end else begin
          if (e.start < base && ee > endr) sp = rmap_pkg::SPLIT_MID;
          else if (e.start < base && ee > base) sp = rmap_pkg::SPLIT_TAIL;
          else if (e.start >= base && e.start < endr && ee > endr)
            sp = rmap_pkg::SPLIT_HEAD;
          else if (e.start >= base && ee <= endr) sp = rmap_pkg::SPLIT_FULL;
        end
        room = rmap_pkg::RW'(held) + rmap_pkg::RW'(rmap_pkg::shift_amt(sp));
        if (sp == rmap_pkg::SPLIT_NONE) begin
          i_next = i + rmap_pkg::cnt_t'(1);
          st_next = rmap_pkg::S_LOOP;
        end else if (room > rmap_pkg::RW'(rmap_pkg::MAX_ENTRIES)) begin
          r_status_next = rmap_pkg::ST_OVF;
          st_next = rmap_pkg::S_DONE;
        end else begin
          split_next = sp;
          amt_next = rmap_pkg::shift_amt(sp);
          pos_next = (sp == rmap_pkg::SPLIT_INS || sp == rmap_pkg::SPLIT_GAP) ?
                     i : i + rmap_pkg::cnt_t'(1);
          k_next = held;
          st_next = rmap_pkg::S_SH;
        end
      end
      // open room: move entries up by amt, top first
      rmap_pkg::S_SH: begin
        if (amt != 2'd0 && k > pos) begin
          mreq.rd_addr = sh_dst[rmap_pkg::AW-1:0] - rmap_pkg::AW'(amt);
          st_next = rmap_pkg::S_SHW;
        end else begin
          held_next = held + rmap_pkg::cnt_t'(amt);
          j_next = '0;
          st_next = rmap_pkg::S_WR;
        end
      end
      rmap_pkg::S_SHW: begin
        mreq.wr_en = 1'b1;
        mreq.wr_addr = sh_dst[rmap_pkg::AW-1:0];
        mreq.wr_data = rd_data;
        k_next = k - rmap_pkg::cnt_t'(1);
        st_next = rmap_pkg::S_SH;
      end
      // write the pieces, one per cycle
      rmap_pkg::S_WR: begin
        mreq.wr_en = 1'b1;
        mreq.wr_addr = slot[rmap_pkg::AW-1:0];
        mreq.wr_data.start = bs;
        mreq.wr_data.len = bt - bs;
        mreq.wr_data.kind = (pc.hit && !is_tag) ? kind : e.kind;
        if (pc.hit && is_tag) mreq.wr_data.tags = tnew;
        else if (pc.hit && (split == rmap_pkg::SPLIT_INS || split == rmap_pkg::SPLIT_GAP))
          mreq.wr_data.tags = '0;
        else mreq.wr_data.tags = e.tags;
        if (j == rmap_pkg::piece_cnt(split) - 2'd1) st_next = rmap_pkg::S_UPD;
        else j_next = j + 2'd1;
      end
      rmap_pkg::S_UPD: begin
        i_next = i + rmap_pkg::cnt_t'(rmap_pkg::piece_cnt(split));
        case (split)
          rmap_pkg::SPLIT_GAP: begin
            base_next = e.start;
            span_next = endr - e.start;
          end
          rmap_pkg::SPLIT_FULL, rmap_pkg::SPLIT_TAIL: begin
            base_next = ee;
            span_next = endr - ee;
          end
          default: span_next = '0;
        endcase
        st_next = rmap_pkg::S_LOOP;
      end
      // merge pass over touching neighbors of equal type
      rmap_pkg::S_M_TOP: begin
        if (rmap_pkg::RW'(i) + rmap_pkg::RW'(1) < rmap_pkg::RW'(held)) begin
          mreq.rd_addr = i[rmap_pkg::AW-1:0];
          st_next = rmap_pkg::S_M_LD0;
        end else begin
          if (op == rmap_pkg::MODE_FIND) r_addr_next = faddr;
          st_next = rmap_pkg::S_DONE;
        end
      end
      rmap_pkg::S_M_LD0: begin
        e_next = rd_data;
        ee_next = rd_data.start + rd_data.len;
        slot = i + rmap_pkg::cnt_t'(1);
        mreq.rd_addr = slot[rmap_pkg::AW-1:0];
        st_next = rmap_pkg::S_M_LD1;
      end
      rmap_pkg::S_M_LD1: begin
        if (ee == rd_data.start && e.kind == rd_data.kind) begin
          mreq.wr_en = 1'b1;
          mreq.wr_addr = i[rmap_pkg::AW-1:0];
          mreq.wr_data = e;
          mreq.wr_data.len = e.len + rd_data.len;
          k_next = i + rmap_pkg::cnt_t'(1);
          st_next = rmap_pkg::S_C_SH;
        end else begin
          i_next = i + rmap_pkg::cnt_t'(1);
          st_next = rmap_pkg::S_M_TOP;
        end
      end
      // close the hole: move entries down by one
      rmap_pkg::S_C_SH: begin
        if (rmap_pkg::RW'(k) + rmap_pkg::RW'(1) < rmap_pkg::RW'(held)) begin
          slot = k + rmap_pkg::cnt_t'(1);
          mreq.rd_addr = slot[rmap_pkg::AW-1:0];
          st_next = rmap_pkg::S_C_SHW;
        end else begin
          held_next = held - rmap_pkg::cnt_t'(1);
          st_next = rmap_pkg::S_M_TOP;
        end
      end
      rmap_pkg::S_C_SHW: begin
        mreq.wr_en = 1'b1;
        mreq.wr_addr = k[rmap_pkg::AW-1:0];
        mreq.wr_data = rd_data;
        k_next = k + rmap_pkg::cnt_t'(1);
        st_next = rmap_pkg::S_C_SH;
      end
      // find-free scan
      rmap_pkg::S_F_CHK: begin
        amask_next = align - 64'd1;
        if ((align & (align - 64'd1)) != 64'd0) begin
          r_status_next = rmap_pkg::ST_ALIGN;
          st_next = rmap_pkg::S_DONE;
        end else begin
          i_next = '0;
          st_next = rmap_pkg::S_F_TOP;
        end
      end
      rmap_pkg::S_F_TOP: begin
        if (i < held) begin
          mreq.rd_addr = i[rmap_pkg::AW-1:0];
          st_next = rmap_pkg::S_F_LD;
        end else begin
          r_status_next = rmap_pkg::ST_NONE;
          st_next = rmap_pkg::S_DONE;
        end
      end
      rmap_pkg::S_F_LD: begin
        e_next = rd_data;
        ee_next = rd_data.start + rd_data.len;
        st_next = rmap_pkg::S_F_A;
      end
      rmap_pkg::S_F_A: begin
        faddr_next = (align != 64'd0) ? ((e.start + amask) & ~amask) : e.start;
        fskip_next = (e.kind != usable_code) || (e.len < want);
        st_next = rmap_pkg::S_F_B;
      end
      rmap_pkg::S_F_B: begin
        if (!fskip && faddr >= e.start && faddr < ee && (ee - faddr) >= want &&
            rmap_pkg::tags_match(e.tags, mask, rule)) begin
          base_next = faddr;
          span_next = want;
          kind_next = used_code;
          st_next = rmap_pkg::S_CLIP;
        end else begin
          i_next = i + rmap_pkg::cnt_t'(1);
          st_next = rmap_pkg::S_F_TOP;
        end
      end
      rmap_pkg::S_R_LD: begin
        r_addr_next = rd_data.start;
        r_len_next = rd_data.len;
        r_type_next = rd_data.kind;
        r_tags_next = rd_data.tags;
        st_next = rmap_pkg::S_DONE;
      end
      rmap_pkg::S_DONE: begin
        if (res_ready) st_next = rmap_pkg::S_IDLE;
      end
      default: st_next = rmap_pkg::S_IDLE;
    endcase
  end

  assign idle = (st == rmap_pkg::S_IDLE);
  assign res_valid = (st == rmap_pkg::S_DONE);
  assign res = '{status: r_status, address: r_addr, entry_length: r_len,
                 entry_type: r_type, entry_tags: r_tags, entry_total: 7'(held)};

endmodule

>>> rtl/core/memory_region_map_allocator.sv
// top level of the region map allocator: handshakes, config registers, result register
// depends on rmap_pkg, rmap_mem and rmap_seq
`timescale 1ns / 1ps

//  channel   handshake               payload
//  request   in_valid / in_ready     mode start_req size region_type mask align
//                                    match_rule entry_index
//  result    out_valid / out_ready   status address entry_length entry_type
//                                    entry_tags entry_total
//  config    cfg_valid / cfg_ready   cfg_index cfg_data
//
//  one request at a time; a request runs longer the more table entries its scan,
//  shift and merge passes touch, since all table traffic goes through the single
//  read and single write port of the table memory (a moved entry is read, then
//  written; claim and tag scan via S_LOOP, S_LD, S_EVAL; find-free via S_F_TOP,
//  S_F_LD, S_F_A, S_F_B; merge compares via S_M_TOP, S_M_LD0, S_M_LD1)
//  rst clears the entry count and the sequencer; table contents need no clearing
//  a finished result sits in the output register while the next request is taken;
//  the sequencer waits at its end only if that register is still full

module memory_region_map_allocator (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  mode,
  input  logic [63:0] start_req,
  input  logic [63:0] size,
  input  logic [7:0]  region_type,
  input  logic [31:0] mask,
  input  logic [63:0] align,
  input  logic [2:0]  match_rule,
  input  logic [5:0]  entry_index,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [63:0] address,
  output logic [63:0] entry_length,
  output logic [7:0]  entry_type,
  output logic [31:0] entry_tags,
  output logic [6:0]  entry_total,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  rmap_pkg::req_t     req;
  rmap_pkg::res_t     res;
  rmap_pkg::mem_req_t mreq;
  rmap_pkg::entry_t   rd_data;
  logic               seq_idle, res_valid, res_ready, start;
  logic [7:0]         usable_code, used_code;

  // config registers are always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      usable_code <= 8'd1;
      used_code   <= 8'd2;
    end else if (cfg_valid) begin
      case (cfg_index)
        rmap_pkg::REG_USABLE: usable_code <= cfg_data;
        rmap_pkg::REG_USED:   used_code   <= cfg_data;
        default: ;
      endcase
    end
  end

  // a new request starts only when the sequencer is parked
  assign in_ready = seq_idle;
  assign start    = in_valid && in_ready;

  assign req = '{mode: mode, start_req: start_req, size: size, region_type: region_type,
                 mask: mask, align: align, match_rule: match_rule,
                 entry_index: entry_index};

  // output slot is free when empty or being drained this cycle
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      status       <= res.status;
      address      <= res.address;
      entry_length <= res.entry_length;
      entry_type   <= res.entry_type;
      entry_tags   <= res.entry_tags;
      entry_total  <= res.entry_total;
    end
  end

  rmap_mem u_mem (
    .clk     (clk),
    .mreq    (mreq),
    .rd_data (rd_data)
  );

  rmap_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .req         (req),
    .usable_code (usable_code),
    .used_code   (used_code),
    .res_ready   (res_ready),
    .rd_data     (rd_data),
    .mreq        (mreq),
    .idle        (seq_idle),
    .res_valid   (res_valid),
    .res         (res)
  );

endmodule

>>> verif/tb_top.sv
// self-checking testbench for memory_region_map_allocator
// holds its own region-table predictor; depends on rmap_pkg and the rtl
`timescale 1ns / 1ps

module tb_top;

  localparam int TBL_DEPTH = rmap_pkg::MAX_ENTRIES;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  mode = rmap_pkg::MODE_READ;
  logic [63:0] start_req = '0;
  logic [63:0] size = '0;
  logic [7:0]  region_type = '0;
  logic [31:0] mask = '0;
  logic [63:0] align = '0;
  logic [2:0]  match_rule = rmap_pkg::RULE_IGNORE;
  logic [5:0]  entry_index = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [63:0] address;
  logic [63:0] entry_length;
  logic [7:0]  entry_type;
  logic [31:0] entry_tags;
  logic [6:0]  entry_total;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = rmap_pkg::REG_USABLE;
  logic [7:0]  cfg_data = '0;

  memory_region_map_allocator DUT (.*);

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor copy of the region table and config
  logic [63:0] pm_start [TBL_DEPTH];
  logic [63:0] pm_len   [TBL_DEPTH];
  logic [7:0]  pm_kind  [TBL_DEPTH];
  logic [31:0] pm_tags  [TBL_DEPTH];
  int          pm_count;
  logic [7:0]  pm_usable;
  logic [7:0]  pm_used;

  rmap_pkg::res_t expected_results [$];
  int          mismatch_count;
  int          send_idle_pct;
  int          recv_idle_pct;

  function automatic bit pm_room(int n);
    return pm_count + n <= TBL_DEPTH;
  endfunction

  function automatic void pm_copy(int d, int s);
    pm_start[d] = pm_start[s];
    pm_len[d]   = pm_len[s];
    pm_kind[d]  = pm_kind[s];
    pm_tags[d]  = pm_tags[s];
  endfunction

  function automatic void pm_open(int pos);
    for (int k = pm_count; k > pos; k--) pm_copy(k, k - 1);
    pm_count++;
  endfunction

  function automatic void pm_close(int pos);
    for (int k = pos; k + 1 < pm_count; k++) pm_copy(k, k + 1);
    pm_count--;
  endfunction

  function automatic void pm_set(int pos, logic [63:0] b, logic [63:0] l, logic [7:0] t);
    pm_start[pos] = b;
    pm_len[pos]   = l;
    pm_kind[pos]  = t;
    pm_tags[pos]  = '0;
  endfunction

  function automatic void pm_cut1(int pos, logic [63:0] off);
    pm_open(pos + 1);
    pm_copy(pos + 1, pos);
    pm_len[pos] = off;
    pm_start[pos + 1] += off;
    pm_len[pos + 1] -= off;
  endfunction

  function automatic void pm_cut2(int pos, logic [63:0] a, logic [63:0] b);
    pm_open(pos + 1);
    pm_open(pos + 1);
    pm_copy(pos + 1, pos);
    pm_copy(pos + 2, pos);
    pm_start[pos + 2] += b;
    pm_len[pos + 2] -= b;
    pm_start[pos + 1] += a;
    pm_len[pos + 1] = b - a;
    pm_len[pos] = a;
  endfunction

  function automatic void pm_merge();
    int i;
    i = 0;
    while (i + 1 < pm_count) begin
      if (pm_start[i] + pm_len[i] == pm_start[i + 1] && pm_kind[i] == pm_kind[i + 1]) begin
        pm_len[i] += pm_len[i + 1];
        pm_close(i + 1);
      end else begin
        i++;
      end
    end
  endfunction

  function automatic logic [2:0] pm_claim(logic [63:0] b, logic [63:0] sp, logic [7:0] t);
    logic [63:0] e, es, ee;
    if (sp > ~b) sp = ~b;
    e = b + sp;
    for (int i = 0; i < pm_count && sp != 0; i++) begin
      es = pm_start[i];
      ee = es + pm_len[i];
      if (e <= es) begin
        if (!pm_room(1)) return rmap_pkg::ST_OVF;
        pm_open(i);
        pm_set(i, b, sp, t);
        sp = 0;
      end else if (b < es) begin
        if (!pm_room(1)) return rmap_pkg::ST_OVF;
        pm_open(i);
        pm_set(i, b, es - b, t);
        sp -= es - b;
        b = es;
      end else if (b == es) begin
        if (sp >= pm_len[i]) begin
          pm_kind[i] = t;
          sp -= pm_len[i];
          b += pm_len[i];
        end else begin
          if (!pm_room(1)) return rmap_pkg::ST_OVF;
          pm_cut1(i, sp);
          pm_kind[i] = t;
          sp = 0;
        end
      end else if (b < ee) begin
        if (e >= ee) begin
          if (!pm_room(1)) return rmap_pkg::ST_OVF;
          pm_cut1(i, b - es);
          pm_kind[i + 1] = t;
          sp -= pm_len[i + 1];
          b = ee;
          i++;
        end else begin
          if (!pm_room(2)) return rmap_pkg::ST_OVF;
          pm_cut2(i, b - es, e - es);
          pm_kind[i + 1] = t;
          sp = 0;
          i += 2;
        end
      end
    end
    if (sp != 0) begin
      if (!pm_room(1)) return rmap_pkg::ST_OVF;
      pm_open(pm_count);
      pm_set(pm_count - 1, b, sp, t);
    end
    pm_merge();
    return rmap_pkg::ST_OK;
  endfunction

  function automatic void pm_apply(int pos, logic [31:0] m, bit set);
    if (set) pm_tags[pos] |= m;
    else pm_tags[pos] &= ~m;
  endfunction

  function automatic logic [2:0] pm_tag(logic [63:0] b, logic [63:0] sp, logic [31:0] m,
                                        bit set);
    logic [63:0] e, es, ee;
    if (sp > ~b) sp = ~b;
    if (sp == 0) return rmap_pkg::ST_OK;
    e = b + sp;
    for (int i = 0; i < pm_count; i++) begin
      es = pm_start[i];
      ee = es + pm_len[i];
      if (es < b && ee > e) begin
        if (!pm_room(2)) return rmap_pkg::ST_OVF;
        pm_cut2(i, b - es, e - es);
        pm_apply(i + 1, m, set);
        i += 2;
      end else if (es < b && ee > b) begin
        if (!pm_room(1)) return rmap_pkg::ST_OVF;
        pm_cut1(i, b - es);
        pm_apply(i + 1, m, set);
        i++;
      end else if (es >= b && es < e && ee > e) begin
        if (!pm_room(1)) return rmap_pkg::ST_OVF;
        pm_cut1(i, e - es);
        pm_apply(i, m, set);
        i++;
      end else if (es >= b && ee <= e) begin
        pm_apply(i, m, set);
      end
    end
    return rmap_pkg::ST_OK;
  endfunction

  function automatic bit pm_match(logic [31:0] t, logic [31:0] m, logic [2:0] r);
    case (r)
      rmap_pkg::RULE_IGNORE:  return 1'b1;
      rmap_pkg::RULE_EXACT:   return t == m;
      rmap_pkg::RULE_ALL_SET: return (t & m) == m;
      rmap_pkg::RULE_ANY_SET: return (t & m) != 0;
      rmap_pkg::RULE_ALL_CLR: return (~t & m) == m;
      rmap_pkg::RULE_ANY_CLR: return (~t & m) != 0;
      default:                return 1'b0;
    endcase
  endfunction

  function automatic logic [2:0] pm_find(logic [63:0] want, logic [63:0] al,
                                         logic [31:0] m, logic [2:0] r,
                                         output logic [63:0] addr);
    logic [63:0] es, ee, a;
    addr = '0;
    if ((al & (al - 1)) != 0) return rmap_pkg::ST_ALIGN;
    for (int i = 0; i < pm_count; i++) begin
      es = pm_start[i];
      ee = es + pm_len[i];
      a = es;
      if (pm_kind[i] != pm_usable || pm_len[i] < want) continue;
      if (al != 0) begin
        a = (es + (al - 1)) & ~(al - 1);
        if (a < es) continue;
      end
      if (a < ee && ee - a >= want && pm_match(pm_tags[i], m, r)) begin
        if (pm_claim(a, want, pm_used) != rmap_pkg::ST_OK) return rmap_pkg::ST_OVF;
        addr = a;
        return rmap_pkg::ST_OK;
      end
    end
    return rmap_pkg::ST_NONE;
  endfunction

  // works out the result of one request and updates the predicted table
  function automatic rmap_pkg::res_t predict_region_op(rmap_pkg::req_t q);
    rmap_pkg::res_t r;
    logic [63:0] a;
    r = '0;
    case (q.mode)
      rmap_pkg::MODE_CLAIM: r.status = pm_claim(q.start_req, q.size, q.region_type);
      rmap_pkg::MODE_TAG:   r.status = pm_tag(q.start_req, q.size, q.mask, 1'b1);
      rmap_pkg::MODE_UNTAG: r.status = pm_tag(q.start_req, q.size, q.mask, 1'b0);
      rmap_pkg::MODE_FIND: begin
        r.status = pm_find(q.size, q.align, q.mask, q.match_rule, a);
        r.address = a;
      end
      rmap_pkg::MODE_READ: begin
        if (q.entry_index < pm_count) begin
          r.address      = pm_start[q.entry_index];
          r.entry_length = pm_len[q.entry_index];
          r.entry_type   = pm_kind[q.entry_index];
          r.entry_tags   = pm_tags[q.entry_index];
        end else begin
          r.status = rmap_pkg::ST_RANGE;
        end
      end
      default: ;
    endcase
    r.entry_total = pm_count[6:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // result checker: random stall, compare against oldest expectation
  always @(posedge clk) begin
    rmap_pkg::res_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", {61'd0, status}, '0);
      end else begin
        e = expected_results.pop_front();
        if (status !== e.status) report_mismatch("status", status, e.status);
        if (address !== e.address) report_mismatch("address", address, e.address);
        if (entry_length !== e.entry_length)
          report_mismatch("entry_length", entry_length, e.entry_length);
        if (entry_type !== e.entry_type) report_mismatch("entry_type", entry_type, e.entry_type);
        if (entry_tags !== e.entry_tags) report_mismatch("entry_tags", entry_tags, e.entry_tags);
        if (entry_total !== e.entry_total)
          report_mismatch("entry_total", entry_total, e.entry_total);
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= rst ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
  end

  // sends one request, predicting at acceptance; valid drops only while idling
  task automatic send_request(rmap_pkg::req_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    mode        <= q.mode;
    start_req   <= q.start_req;
    size        <= q.size;
    region_type <= q.region_type;
    mask        <= q.mask;
    align       <= q.align;
    match_rule  <= q.match_rule;
    entry_index <= q.entry_index;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_results.push_back(predict_region_op(q));
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == rmap_pkg::REG_USABLE) pm_usable = val;
    else pm_used = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic rmap_pkg::req_t make_req(logic [2:0] m, logic [63:0] s, logic [63:0] l);
    rmap_pkg::req_t q;
    q = '0;
    q.mode = m;
    q.start_req = s;
    q.size = l;
    return q;
  endfunction

  // pick a value, mostly near table entries, so ranges overlap existing regions
  function automatic logic [63:0] near_addr();
    logic [63:0] v;
    if (pm_count != 0 && $urandom_range(3) != 0) begin
      v = pm_start[$urandom_range(pm_count - 1)];
      return v + $urandom_range(64) - 32;
    end
    return {$urandom, $urandom} >> $urandom_range(63);
  endfunction

  function automatic rmap_pkg::req_t random_req();
    rmap_pkg::req_t q;
    q = '0;
    q.mode        = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
    q.start_req   = near_addr();
    q.size        = ($urandom_range(15) == 0) ? {$urandom, $urandom} : 64'($urandom_range(128));
    q.region_type = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(3));
    q.mask        = ($urandom_range(1)) ? $urandom : 32'($urandom_range(15));
    case ($urandom_range(5))
      0: q.align = {$urandom, $urandom};
      1, 2: q.align = '0;
      default: q.align = 64'd1 << $urandom_range(63);
    endcase
    q.match_rule  = 3'($urandom);
    q.entry_index = ($urandom_range(1)) ? 6'($urandom) : 6'($urandom_range(pm_count));
    // keep find-free sizes mostly small so allocations succeed
    if (q.mode == rmap_pkg::MODE_FIND && $urandom_range(4) != 0)
      q.size = 64'($urandom_range(32));
    if (q.mode == rmap_pkg::MODE_FIND && q.align > 64 && $urandom_range(3) != 0)
      q.align = 64'd16;
    return q;
  endfunction

  // directed: field extremes, every mode and the named corner cases
  task automatic test_directed();
    rmap_pkg::req_t q;
    send_request(make_req(rmap_pkg::MODE_READ, '0, '0));              // read on empty table
    send_request(make_req(rmap_pkg::MODE_CLAIM, 64'h1000, 64'h1000));
    q = make_req(rmap_pkg::MODE_CLAIM, 64'h0, 64'h1000); q.region_type = 8'd1;
    send_request(q);
    q = make_req(rmap_pkg::MODE_CLAIM, 64'h3000, 64'h800); q.region_type = 8'hff;
    send_request(q);
    send_request(make_req(rmap_pkg::MODE_CLAIM, 64'h1800, 64'h2000)); // gap fill and split
    send_request(make_req(rmap_pkg::MODE_CLAIM, 64'h10, 0));          // empty range
    q = make_req(rmap_pkg::MODE_CLAIM, 64'hffff_ffff_ffff_ff00, '1); q.region_type = 8'd1;
    send_request(q);                                                  // cut at the top
    q = make_req(rmap_pkg::MODE_TAG, 64'h100, 64'h200); q.mask = '1;
    send_request(q);                                                  // middle split
    q = make_req(rmap_pkg::MODE_UNTAG, 64'h180, 64'h4000); q.mask = 32'h5555_5555;
    send_request(q);
    q = make_req(rmap_pkg::MODE_TAG, '1, '1); q.mask = 32'h1; send_request(q);
    q = make_req(rmap_pkg::MODE_FIND, '0, 64'h40); q.align = 64'h3;
    send_request(q);                                                  // bad alignment
    q = make_req(rmap_pkg::MODE_FIND, '0, 64'h40); q.align = 64'h100;
    q.match_rule = rmap_pkg::RULE_ALL_SET;
    q.mask = 32'h2; send_request(q);
    q = make_req(rmap_pkg::MODE_FIND, '0, 64'h10); q.align = 64'h8000_0000_0000_0000;
    send_request(q);
    q = make_req(rmap_pkg::MODE_FIND, '0, '1); send_request(q);       // none found
    for (int r = rmap_pkg::RULE_IGNORE; r <= 7; r++) begin
      q = make_req(rmap_pkg::MODE_FIND, '0, 64'h8); q.match_rule = 3'(r);
      q.mask = 32'hAAAA_AAAA;
      send_request(q);
    end
    q = make_req(3'd7, '1, '1); send_request(q);                      // unknown mode
    q = make_req(rmap_pkg::MODE_READ, '0, '0); q.entry_index = 6'd63; send_request(q);
    q = make_req(rmap_pkg::MODE_READ, '0, '0); q.entry_index = 6'd2; send_request(q);
  endtask

  // fill the table to force overflow on insert and split
  task automatic test_overflow();
    rmap_pkg::req_t q;
    for (int i = 0; i < 70; i++) begin
      q = make_req(rmap_pkg::MODE_CLAIM, 64'h10_0000 + 64'(i) * 64'h20, 64'h10);
      q.region_type = 8'(i);
      send_request(q);
    end
    q = make_req(rmap_pkg::MODE_TAG, 64'h10_0004, 64'h4); q.mask = 32'h8000_0000;
    send_request(q);
    q = make_req(rmap_pkg::MODE_FIND, '0, 64'h2); send_request(q);
    q = make_req(rmap_pkg::MODE_READ, '0, '0); q.entry_index = 6'd63; send_request(q);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if (pm_count >= 60 && $urandom_range(3) == 0) begin
        // wide claim with one type collapses the table back down
        rmap_pkg::req_t q;
        q = make_req(rmap_pkg::MODE_CLAIM, '0, '1);
        q.region_type = pm_usable;
        send_request(q);
      end else begin
        send_request(random_req());
      end
    end
  endtask

  // holds off until all results are in, then resumes
  task automatic test_pause();
    drain_results();
    test_random(40);
  endtask

  initial begin
    mismatch_count = 0;
    send_idle_pct = 27;
    recv_idle_pct = 70;
    pm_count = 0;
    pm_usable = 8'd1;
    pm_used = 8'd2;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_overflow();
    write_reg(rmap_pkg::REG_USABLE, 8'd0);
    write_reg(rmap_pkg::REG_USED, 8'hff);
    test_random(600);
    send_idle_pct = 70;
    recv_idle_pct = 27;
    test_pause();
    write_reg(rmap_pkg::REG_USABLE, 8'hff);
    write_reg(rmap_pkg::REG_USED, 8'd0);
    test_random(600);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(rmap_pkg::REG_USABLE, 8'd1);
    write_reg(rmap_pkg::REG_USED, 8'd2);
    test_random(600);
    drain_results();
    if (mismatch_count == 0) begin
      $display("memory_region_map_allocator test passed");
    end else begin
      $display("memory_region_map_allocator test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2s;
    $display("memory_region_map_allocator test failed");
    $finish;
  end

endmodule
